// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/ude_pkg.sv =====
// ----------------------------------------------------------------------------
// ude_pkg
// Shared constants, types and the month table for the date to epoch converter.
// ----------------------------------------------------------------------------
package ude_pkg;

    // calendar constants
    localparam int unsigned EPOCH_YEAR   = 1970;
    localparam int unsigned LEAPS_EPOCH  = 477;     // leap years in 1..1969
    localparam int unsigned DAYS_YEAR    = 365;
    localparam int unsigned SEC_PER_DAY  = 86400;
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned SEC_PER_MIN  = 60;

    // divide by 100 as multiply by reciprocal, exact for 12-bit values
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;

    // field widths
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned OUT_W   = 32;

    // internal widths
    localparam int unsigned DAYS_W = 21;    // whole day count plus day of month
    localparam int unsigned HMS_W  = 17;    // seconds within the day
    localparam int unsigned CUM_W  = 9;     // days before month
    localparam int unsigned Q100_W = 6;     // year / 100

    // item between the day counter and the seconds scaler
    typedef struct packed {
        logic                vld;
        logic                stamp;
        logic [DAYS_W-1:0]   days;   // day count plus day of month, before minus one
        logic [HMS_W-1:0]    hms;
    } t_days_item;

    // days before the first of the month; month 0 as January, above 12 as a full year
    function automatic logic [CUM_W-1:0] days_before(input logic [MONTH_W-1:0] month);
        logic [CUM_W-1:0] d;
        case (month)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            4'd12:      d = 9'd334;
            default:    d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/utc_date_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// utc_date_to_epoch_seconds
// UTC calendar time stamp to 32-bit Unix epoch seconds, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid with the time stamp fields, o_stall back. An item
//   is taken at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid with o_epoch_seconds, i_stall back. A result is
//   taken at a clock edge with o_valid high and i_stall low.
//   One item per cycle is accepted when the output is not stalled.
//   Stages: year quotients and time of day, whole years and leap count, day
//   sum, multiply by 86400, final sum into the output register.
//   When the receiver stalls while a result is waiting, the whole pipeline
//   holds and o_stall rises; nothing is dropped or repeated. Empty slots are
//   filled while the output is idle.
//   A stamp with stamp_valid low still yields one result, with value zero.
//   Synchronous active-low reset clears all valid bits; no result is pending
//   after reset and the block is ready at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utc_date_to_epoch_seconds import ude_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_stamp_valid,
    input  logic [YEAR_W-1:0]  i_year_value,
    input  logic [MONTH_W-1:0] i_month_value,
    input  logic [DAY_W-1:0]   i_day_value,
    input  logic [HOUR_W-1:0]  i_hour_value,
    input  logic [MIN_W-1:0]   i_minute_value,
    input  logic [SEC_W-1:0]   i_second_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [OUT_W-1:0]   o_epoch_seconds
);

    logic       w_en;
    logic       w_out_stamp;
    t_days_item w_days;

    // pipeline advances unless a waiting result is stalled
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    ude_days u_days (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_vld          (i_valid),
        .i_stamp_valid  (i_stamp_valid),
        .i_year_value   (i_year_value),
        .i_month_value  (i_month_value),
        .i_day_value    (i_day_value),
        .i_hour_value   (i_hour_value),
        .i_minute_value (i_minute_value),
        .i_second_value (i_second_value),
        .o_item         (w_days)
    );

    ude_secs u_secs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_item  (w_days),
        .o_valid (o_valid),
        .o_stamp (w_out_stamp),
        .o_secs  (o_epoch_seconds)
    );

    // checks
    `ASSERT_IMPL(a_invalid_zero, i_clk, i_rst_n, o_valid && !w_out_stamp, o_epoch_seconds == '0)
    `ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid)
    `ASSERT_NEXT(a_mid_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(w_days))

endmodule

// ===== sv/ude_days.sv =====
// ----------------------------------------------------------------------------
// ude_days
// Three-stage day counter: year quotients, year and leap terms, day sum.
// ----------------------------------------------------------------------------
module ude_days import ude_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic               i_stamp_valid,
    input  logic [YEAR_W-1:0]  i_year_value,
    input  logic [MONTH_W-1:0] i_month_value,
    input  logic [DAY_W-1:0]   i_day_value,
    input  logic [HOUR_W-1:0]  i_hour_value,
    input  logic [MIN_W-1:0]   i_minute_value,
    input  logic [SEC_W-1:0]   i_second_value,
    output t_days_item         o_item
);

    localparam int unsigned PROD100_W = YEAR_W + 13;

    // stage 1 registers
    logic                r1_vld;
    logic                r1_stamp;
    logic                r1_gt;
    logic [YEAR_W-1:0]   r1_ym;
    logic [YEAR_W-3:0]   r1_n4;
    logic [Q100_W-1:0]   r1_qn;
    logic [Q100_W-1:0]   r1_qy;
    logic [YEAR_W-1:0]   r1_year;
    logic [CUM_W-1:0]    r1_cum;
    logic                r1_late;
    logic [DAY_W-1:0]    r1_day;
    logic [HMS_W-1:0]    r1_hms;

    // stage 2 registers
    logic                r2_vld;
    logic                r2_stamp;
    logic                r2_gt;
    logic [DAYS_W-1:0]   r2_y365;
    logic [10:0]         r2_ldiff;
    logic                r2_leap;
    logic [CUM_W-1:0]    r2_cum;
    logic                r2_late;
    logic [DAY_W-1:0]    r2_day;
    logic [HMS_W-1:0]    r2_hms;

    // stage 3 registers
    logic                r3_vld;
    logic                r3_stamp;
    logic [DAYS_W-1:0]   r3_days;
    logic [HMS_W-1:0]    r3_hms;

    // stage 1 logic: quotients by 100, month table, seconds of the day
    logic [YEAR_W-1:0]    n_prev;
    logic [PROD100_W-1:0] n_pn;
    logic [PROD100_W-1:0] n_py;
    logic [HMS_W-1:0]     n_hms;

    always_comb begin
        n_prev = i_year_value - YEAR_W'(1);
        n_pn   = PROD100_W'(n_prev) * PROD100_W'(DIV100_MUL);
        n_py   = PROD100_W'(i_year_value) * PROD100_W'(DIV100_MUL);
        n_hms  = HMS_W'(i_hour_value) * HMS_W'(SEC_PER_HOUR)
               + HMS_W'(i_minute_value) * HMS_W'(SEC_PER_MIN)
               + HMS_W'(i_second_value);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_stamp <= i_stamp_valid;
            r1_gt    <= (i_year_value > YEAR_W'(EPOCH_YEAR));
            r1_ym    <= i_year_value - YEAR_W'(EPOCH_YEAR);
            r1_n4    <= n_prev[YEAR_W-1:2];
            r1_qn    <= n_pn[DIV100_SHIFT +: Q100_W];
            r1_qy    <= n_py[DIV100_SHIFT +: Q100_W];
            r1_year  <= i_year_value;
            r1_cum   <= days_before(i_month_value);
            r1_late  <= (i_month_value >= MONTH_W'(3));
            r1_day   <= i_day_value;
            r1_hms   <= n_hms;
        end
    end

    // stage 2 logic: whole years, leap count since epoch, leap flag of this year
    logic [DAYS_W-1:0] n_y365;
    logic [10:0]       n_ldiff;
    logic [YEAR_W-1:0] n_rem;
    logic              n_leap;

    always_comb begin
        n_y365  = DAYS_W'(r1_ym) * DAYS_W'(DAYS_YEAR);
        n_ldiff = 11'(r1_n4) - 11'(r1_qn) + 11'(r1_qn[Q100_W-1:2]) - 11'(LEAPS_EPOCH);
        n_rem   = r1_year - YEAR_W'(YEAR_W'(r1_qy) * YEAR_W'(100));
        n_leap  = (r1_year[1:0] == 2'd0) && ((n_rem != '0) || (r1_qy[1:0] == 2'd0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_stamp <= r1_stamp;
            r2_gt    <= r1_gt;
            r2_y365  <= n_y365;
            r2_ldiff <= n_ldiff;
            r2_leap  <= n_leap;
            r2_cum   <= r1_cum;
            r2_late  <= r1_late;
            r2_day   <= r1_day;
            r2_hms   <= r1_hms;
        end
    end

    // stage 3 logic: total day count, years only counted after the epoch year
    logic [DAYS_W-1:0] n_days;

    always_comb begin
        n_days = (r2_gt ? (r2_y365 + DAYS_W'(r2_ldiff)) : '0)
               + DAYS_W'(r2_cum)
               + DAYS_W'(r2_leap && r2_late)
               + DAYS_W'(r2_day);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_stamp <= r2_stamp;
            r3_days  <= n_days;
            r3_hms   <= r2_hms;
        end
    end

    assign o_item.vld   = r3_vld;
    assign o_item.stamp = r3_stamp;
    assign o_item.days  = r3_days;
    assign o_item.hms   = r3_hms;

endmodule

// ===== sv/ude_secs.sv =====
// ----------------------------------------------------------------------------
// ude_secs
// Two-stage scaler: days times 86400, then minus one day plus time of day.
// ----------------------------------------------------------------------------
module ude_secs import ude_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_days_item       i_item,
    output logic             o_valid,
    output logic             o_stamp,
    output logic [OUT_W-1:0] o_secs
);

    logic             r4_vld;
    logic             r4_stamp;
    logic [OUT_W-1:0] r4_prod;
    logic [HMS_W-1:0] r4_hms;

    logic             r5_vld;
    logic             r5_stamp;
    logic [OUT_W-1:0] r5_secs;

    // stage 4: constant multiply, wraps modulo 2^32
    logic [OUT_W-1:0] n_prod;

    assign n_prod = OUT_W'(i_item.days) * OUT_W'(SEC_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= i_item.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_stamp <= i_item.stamp;
            r4_prod  <= n_prod;
            r4_hms   <= i_item.hms;
        end
    end

    // stage 5: day of month counts from one, invalid stamp gives zero
    logic [OUT_W-1:0] n_secs;

    assign n_secs = r4_stamp ? (r4_prod - OUT_W'(SEC_PER_DAY) + OUT_W'(r4_hms)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_stamp <= r4_stamp;
            r5_secs  <= n_secs;
        end
    end

    assign o_valid = r5_vld;
    assign o_stamp = r5_stamp;
    assign o_secs  = r5_secs;

endmodule
